// ----- src/svf_pkg.sv -----
// ----------------------------------------------------------------------------
// svf_pkg
// Types, constants and helpers shared by the state variable filter design.
// ----------------------------------------------------------------------------
package svf_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned COEF_W     = 24;

  // datapath widths
  localparam int unsigned MUL_W  = 33;  // signed operand width of the shared multiplier
  localparam int unsigned PROD_W = 66;  // its full product
  localparam int unsigned ACC_W  = 41;  // x - a*s1 - b*s2
  localparam int unsigned A_W    = 26;  // a = 1 + 2gR, q.20
  localparam int unsigned B_W    = 28;  // b = g*g, q.20
  localparam int unsigned LO_W   = 40;  // low partial product of acc*h
  localparam int unsigned WIDE_W = 48;  // headroom ahead of 32 bit saturation
  localparam int unsigned STATE_W = 32;

  localparam logic [COEF_W-1:0] COEF_ONE = 24'h800000;  // 1.0 in q1.23
  localparam logic [COEF_W-1:0] G_RESET  = 24'd68700;
  localparam logic [COEF_W-1:0] R_RESET  = 24'h800000;
  localparam logic [COEF_W-1:0] H_RESET  = 24'd7389000;
  localparam logic [A_W-1:0]    A_ONE    = 26'h0100000;  // 1.0 in q.20

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_G      = 2'd0,
    CFG_DAMPING     = 2'd1,
    CFG_NORM        = 2'd2,
    CFG_FILTER_TYPE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FT_LOWPASS  = 2'd0,
    FT_BANDPASS = 2'd1,
    FT_HIGHPASS = 2'd2,
    FT_NOTCH    = 2'd3
  } filter_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GR,
    ST_GG,
    ST_AS1,
    ST_BS2,
    ST_ACC,
    ST_HLO,
    ST_HHI,
    ST_HP,
    ST_GHP,
    ST_BP,
    ST_GBP,
    ST_LP,
    ST_DONE
  } svf_state_e;

  // saturate a wide signed word to 32 bits
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = WIDE_W'(-32'sh7fffffff - 32'sd1);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return -32'sh7fffffff - 32'sd1;
    end
    return v[STATE_W-1:0];
  endfunction

endpackage

// ----- src/state_variable_filter_top.sv -----
// ----------------------------------------------------------------------------
// state_variable_filter_top
// Trapezoidal state variable filter, per-channel integrators, one shared
// multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
// schedule: one sample in flight; a new sample is taken only back at idle,
//   after eight passes through the single 33x33 multiplier plus the
//   add/saturate steps between dependent products and a free output register
// reset: coefficients return to their defaults, filter type to lowpass,
//   all integrator states to zero, output register empty
module state_variable_filter_top #(
  parameter int unsigned CHANNELS    = 2,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [svf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [svf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // sample input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                channel_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  // sample output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o
);
  import svf_pkg::*;

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned OUT_W = 34;  // x - bp before output saturation
  localparam logic signed [OUT_W-1:0] OUT_MAX =
    $signed((OUT_W'(1) << (SAMPLE_BITS - 1)) - OUT_W'(1));
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX - OUT_W'(1);

  // --------------------------------------------------------------------------
  // configuration registers, damping and normalizer clamp to 1.0 on write
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0] coef_g_q;
  logic [COEF_W-1:0] coef_r_q;
  logic [COEF_W-1:0] coef_h_q;
  filter_type_e      filt_q;
  logic [COEF_W-1:0] wdata_clamped;

  assign wdata_clamped = (cfg_wdata_i > COEF_ONE) ? COEF_ONE : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_g_q <= G_RESET;
      coef_r_q <= R_RESET;
      coef_h_q <= H_RESET;
      filt_q   <= FT_LOWPASS;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_COEF_G:      coef_g_q <= cfg_wdata_i;
        CFG_DAMPING:     coef_r_q <= wdata_clamped;
        CFG_NORM:        coef_h_q <= wdata_clamped;
        CFG_FILTER_TYPE: filt_q   <= filter_type_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  svf_state_e state_q, state_d;
  logic       in_fire;
  logic       out_free;
  logic       out_valid_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state: a straight walk through the multiply schedule
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_GR;
      ST_GR:   state_d = ST_GG;
      ST_GG:   state_d = ST_AS1;
      ST_AS1:  state_d = ST_BS2;
      ST_BS2:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_HLO;
      ST_HLO:  state_d = ST_HHI;
      ST_HHI:  state_d = ST_HP;
      ST_HP:   state_d = ST_GHP;
      ST_GHP:  state_d = ST_BP;
      ST_BP:   state_d = ST_GBP;
      ST_GBP:  state_d = ST_LP;
      ST_LP:   state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [CH_W-1:0]               ch_q;
  logic                          ch_ok_q;
  logic signed [STATE_W-1:0]     s1_q, s2_q;
  logic [A_W-1:0]                a_q;
  logic [B_W-1:0]                b_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic [LO_W-1:0]               lo_q;
  logic signed [STATE_W-1:0]     hp_q, bp_q, lp_q;
  logic signed [PROD_W-1:0]      prod_q;

  logic signed [MUL_W-1:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0]      mul_p;

  // integrator states, one pair per channel
  logic signed [STATE_W-1:0]     integ_one_q [CHANNELS];
  logic signed [STATE_W-1:0]     integ_two_q [CHANNELS];

  logic [CH_W-1:0]               ch_idx;
  logic                          ch_ok;

  // channel one exists only when there are at least two channels
  assign ch_idx = CH_W'(channel_i);
  assign ch_ok  = !channel_i || (CHANNELS > 1);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_GR: begin
        mul_a = MUL_W'(coef_g_q);
        mul_b = MUL_W'(coef_r_q);
      end
      ST_GG: begin
        mul_a = MUL_W'(coef_g_q);
        mul_b = MUL_W'(coef_g_q);
      end
      ST_AS1: begin
        mul_a = MUL_W'(a_q);
        mul_b = MUL_W'(s1_q);
      end
      ST_BS2: begin
        mul_a = MUL_W'(b_q);
        mul_b = MUL_W'(s2_q);
      end
      // acc*h is split into an unsigned low half and a signed high half
      ST_HLO: begin
        mul_a = MUL_W'(acc_q[15:0]);
        mul_b = MUL_W'(coef_h_q);
      end
      ST_HHI: begin
        mul_a = MUL_W'($signed(acc_q[ACC_W-1:16]));
        mul_b = MUL_W'(coef_h_q);
      end
      ST_GHP: begin
        mul_a = MUL_W'(coef_g_q);
        mul_b = MUL_W'(hp_q);
      end
      ST_GBP: begin
        mul_a = MUL_W'(coef_g_q);
        mul_b = MUL_W'(bp_q);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // recombine acc*h and drop 23 fraction bits (floor)
  logic signed [63:0]         hp_tot;
  logic signed [WIDE_W-1:0]   hp_wide;
  logic signed [WIDE_W-1:0]   bp_wide;
  logic signed [WIDE_W-1:0]   lp_wide;

  assign hp_tot  = $signed({prod_q[47:0], 16'h0000}) + $signed({24'h000000, lo_q});
  assign hp_wide = WIDE_W'($signed(hp_tot[63:23]));
  assign bp_wide = WIDE_W'($signed(prod_q[55:20])) + WIDE_W'(s1_q);
  assign lp_wide = WIDE_W'($signed(prod_q[55:20])) + WIDE_W'(s2_q);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x_q     <= sample_in_i;
          ch_q    <= ch_idx;
          ch_ok_q <= ch_ok;
          s1_q    <= ch_ok ? integ_one_q[ch_idx] : '0;
          s2_q    <= ch_ok ? integ_two_q[ch_idx] : '0;
        end
      end
      ST_GG:  a_q   <= {1'b0, prod_q[46:22]} + A_ONE;
      ST_AS1: b_q   <= prod_q[47:20];
      ST_BS2: acc_q <= ACC_W'(x_q) - $signed(prod_q[60:20]);
      ST_ACC: acc_q <= acc_q - $signed(prod_q[60:20]);
      ST_HHI: lo_q  <= prod_q[LO_W-1:0];
      ST_HP:  hp_q  <= sat32(hp_wide);
      ST_BP:  bp_q  <= sat32(bp_wide);
      ST_LP:  lp_q  <= sat32(lp_wide);
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // integrator update and output select
  // --------------------------------------------------------------------------
  logic signed [STATE_W-1:0] s1_new, s2_new;
  logic signed [OUT_W-1:0]   y_sel;
  logic signed [OUT_W-1:0]   y_sat;
  logic                      done_fire;

  assign s1_new    = sat32((WIDE_W'(bp_q) <<< 1) - WIDE_W'(s1_q));
  assign s2_new    = sat32((WIDE_W'(lp_q) <<< 1) - WIDE_W'(s2_q));
  assign done_fire = (state_q == ST_DONE) && out_free;

  always_comb begin
    unique case (filt_q)
      FT_LOWPASS:  y_sel = OUT_W'(lp_q);
      FT_BANDPASS: y_sel = OUT_W'(bp_q);
      FT_HIGHPASS: y_sel = OUT_W'(hp_q);
      FT_NOTCH:    y_sel = OUT_W'(x_q) - OUT_W'(bp_q);
      default:     y_sel = OUT_W'(lp_q);
    endcase
    if (y_sel > OUT_MAX) begin
      y_sat = OUT_MAX;
    end else if (y_sel < OUT_MIN) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = y_sel;
    end
  end

  // a missing channel leaves every state alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        integ_one_q[i] <= '0;
        integ_two_q[i] <= '0;
      end
    end else if (done_fire && ch_ok_q) begin
      integ_one_q[ch_q] <= s1_new;
      integ_two_q[ch_q] <= s2_new;
    end
  end

  // output register, frees the input side while a result waits
  logic signed [SAMPLE_BITS-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // a missing channel gives a zero sample
  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_data_q <= ch_ok_q ? y_sat[SAMPLE_BITS-1:0] : '0;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule

// ----- src/svf_checker.sv -----
// ----------------------------------------------------------------------------
// svf_checker
// Port-level checks for the state variable filter, bound to the top level.
// ----------------------------------------------------------------------------
module svf_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_out_o))
    else $error("result changed while stalled");

  // one sample in flight: busy right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // no result appears right after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // a new result comes with the sequencer back at idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result without return to idle");

endmodule

bind state_variable_filter_top svf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_svf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o)
);
